@@ design/asb_pkg.sv @@
// ----------------------------------------------------------------------------
// asb_pkg
// Shared constants and types for the activity segment builder: register
// indices and reset values, input kind codes and the result queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package asb_pkg;

    // Default width of the internal time counters
    localparam int TIME_BITS_DEF = 32;

    // Width of the time fields on the result port
    localparam int OUT_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INVERT  = 2'd0,
        CFG_STEP    = 2'd1,
        CFG_MIN_GAP = 2'd2,
        CFG_MIN_LEN = 2'd3
    } t_cfg_idx;

    localparam logic [1:0]            RST_FRAME_STEP = 2'd2;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_GAP    = 10'd20;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_LEN    = 10'd20;

    // Input kind codes
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EOS   = 1'b1;

    // Result queue: room for the worst case of one item plus one waiting
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One queued result; v0/v1 are start/end for a segment and
    // total/kept for a summary
    typedef struct packed {
        logic             summ;
        logic [OUT_W-1:0] v0;
        logic [OUT_W-1:0] v1;
        logic             last;
    } t_entry;

endpackage

`default_nettype wire

@@ design/activity_segment_builder_top.sv @@
// ----------------------------------------------------------------------------
// activity_segment_builder_top
// Turns per-frame voice-activity decisions into padded, merged and filtered
// time segments, followed by a totals item at end of stream.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+--------------------------
//  in        | input     | i_in_valid / o_in_ready     | i_kind, i_frame_active
//  out       | output    | o_out_valid / i_out_ready   | o_is_summary, o_seg_start,
//            |           |                             | o_seg_end, o_total_time,
//            |           |                             | o_kept_time, o_last
//  cfg       | input     | i_cfg_we                    | i_cfg_addr, i_cfg_wdata
//
//  One item is taken per cycle while o_in_ready is high; its state update and all
//  its results are formed in that cycle and written into a four-entry result queue.
//  A frame item yields at most one result, an end-of-stream item up to three,
//  which leave the queue one per cycle while i_out_ready is high. Input is taken
//  while the queue holds at most one result, so with the output ready frames go in
//  one per cycle. Reset is synchronous and clears the stream state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module activity_segment_builder_top #(
    parameter int TIME_BITS = asb_pkg::TIME_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input items
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_kind,
    input  wire                                i_frame_active,
    // result items
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_is_summary,
    output logic [asb_pkg::OUT_W-1:0]          o_seg_start,
    output logic [asb_pkg::OUT_W-1:0]          o_seg_end,
    output logic [asb_pkg::OUT_W-1:0]          o_total_time,
    output logic [asb_pkg::OUT_W-1:0]          o_kept_time,
    output logic                               o_last,
    // configuration
    input  wire                                i_cfg_we,
    input  wire  [asb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [asb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import asb_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // configuration registers
    logic                   r_invert;
    logic [1:0]             r_step;
    logic [CFG_DATA_W-1:0]  r_min_gap;
    logic [CFG_DATA_W-1:0]  r_min_len;

    // stream state
    logic [TIME_BITS-1:0]   r_time;
    logic                   r_run_open;
    logic [TIME_BITS-1:0]   r_run_start;
    logic                   r_pend_valid;
    logic [TIME_BITS-1:0]   r_pend_start;
    logic [TIME_BITS-1:0]   r_pend_end;
    logic [TIME_BITS-1:0]   r_kept;

    logic [TIME_BITS-1:0]   n_time;
    logic                   n_run_open;
    logic [TIME_BITS-1:0]   n_run_start;
    logic                   n_pend_valid;
    logic [TIME_BITS-1:0]   n_pend_start;
    logic [TIME_BITS-1:0]   n_pend_end;
    logic [TIME_BITS-1:0]   n_kept;

    // result queue
    t_entry                 r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_head;
    logic [QCNT_W-1:0]      r_count;

    // datapath
    logic                   in_fire;
    logic                   out_fire;
    logic                   is_eos;
    logic                   sel;
    logic [1:0]             half;
    logic [TIME_BITS-1:0]   half_w;
    logic [TIME_BITS:0]     time_sum;
    logic [TIME_BITS:0]     end_sum;
    logic [TIME_BITS-1:0]   close_s;
    logic [TIME_BITS-1:0]   close_e;
    logic [TIME_BITS-1:0]   seg_s;
    logic [TIME_BITS-1:0]   seg_e;
    logic                   do_offer;
    logic                   do_open;
    logic [TIME_BITS:0]     gap_limit;
    logic                   merge;
    logic [TIME_BITS-1:0]   len_p;
    logic                   emit1;
    logic [TIME_BITS:0]     kept_sum1;
    logic [TIME_BITS-1:0]   kept1;
    logic                   pv1;
    logic [TIME_BITS-1:0]   ps1;
    logic [TIME_BITS-1:0]   pe1;
    logic [TIME_BITS-1:0]   len1;
    logic                   emit2;
    logic [TIME_BITS:0]     kept_sum2;
    logic [TIME_BITS-1:0]   kept2;
    logic [QCNT_W-1:0]      push_n;
    logic [QPTR_W-1:0]      slot1;
    logic [QPTR_W-1:0]      slot2;
    logic [QPTR_W-1:0]      slot3;
    t_entry                 ent1;
    t_entry                 ent2;
    t_entry                 ent3;
    t_entry                 head_ent;

    // Handshakes: take an item only while the queue can absorb three results
    assign o_in_ready  = (r_count <= QCNT_W'(QUEUE_DEPTH - 3));
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_fire    = o_out_valid && i_out_ready;

    // Frame selection, padding and time advance
    assign is_eos   = (i_kind == KIND_EOS);
    assign sel      = i_frame_active ^ r_invert;
    assign half     = {1'b0, r_step[1]} + {1'b0, r_step[0]};
    assign half_w   = TIME_BITS'(half);
    assign time_sum = {1'b0, r_time} + (TIME_BITS + 1)'(r_step);
    assign end_sum  = {1'b0, r_time} + {1'b0, half_w};
    assign close_s  = (r_run_start > half_w) ? (r_run_start - half_w) : '0;
    assign close_e  = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];

    // Segment offered to the merge stage: padded on close, bare on flush
    assign seg_s    = is_eos ? r_run_start : close_s;
    assign seg_e    = is_eos ? r_time : close_e;
    assign do_open  = !is_eos && sel && !r_run_open;
    assign do_offer = r_run_open && (is_eos || !sel);

    // Merge test against the pending segment
    assign gap_limit = {1'b0, r_pend_end} + (TIME_BITS + 1)'(r_min_gap);
    assign merge     = r_pend_valid && ({1'b0, seg_s} < gap_limit);

    // First emission: pending segment pushed out by a distant new one
    assign len_p     = r_pend_end - r_pend_start;
    assign emit1     = do_offer && r_pend_valid && !merge
                       && (len_p >= TIME_BITS'(r_min_len));
    assign kept_sum1 = {1'b0, r_kept} + {1'b0, len_p};
    assign kept1     = !emit1 ? r_kept
                     : (kept_sum1[TIME_BITS] ? TIME_MAX : kept_sum1[TIME_BITS-1:0]);

    // Pending segment after the offer
    assign pv1 = do_offer || r_pend_valid;
    assign ps1 = (do_offer && !merge) ? seg_s : r_pend_start;
    assign pe1 = do_offer ? seg_e : r_pend_end;

    // Second emission: pending segment flushed at end of stream
    assign len1      = pe1 - ps1;
    assign emit2     = is_eos && pv1 && (len1 >= TIME_BITS'(r_min_len));
    assign kept_sum2 = {1'b0, kept1} + {1'b0, len1};
    assign kept2     = !emit2 ? kept1
                     : (kept_sum2[TIME_BITS] ? TIME_MAX : kept_sum2[TIME_BITS-1:0]);

    // Next stream state
    always_comb begin
        n_time       = time_sum[TIME_BITS] ? TIME_MAX : time_sum[TIME_BITS-1:0];
        n_run_open   = do_open || (r_run_open && sel);
        n_run_start  = do_open ? r_time : r_run_start;
        n_pend_valid = pv1;
        n_pend_start = ps1;
        n_pend_end   = pe1;
        n_kept       = kept1;
        if (is_eos) begin
            n_time       = '0;
            n_run_open   = 1'b0;
            n_run_start  = '0;
            n_pend_valid = 1'b0;
            n_pend_start = '0;
            n_pend_end   = '0;
            n_kept       = '0;
        end
    end

    // Result entries and their queue slots
    always_comb begin
        ent1.summ = 1'b0;
        ent1.v0   = OUT_W'(r_pend_start);
        ent1.v1   = OUT_W'(r_pend_end);
        ent1.last = !is_eos;
        ent2.summ = 1'b0;
        ent2.v0   = OUT_W'(ps1);
        ent2.v1   = OUT_W'(pe1);
        ent2.last = 1'b0;
        ent3.summ = 1'b1;
        ent3.v0   = OUT_W'(r_time);
        ent3.v1   = OUT_W'(kept2);
        ent3.last = 1'b1;
    end

    assign slot1  = r_head + r_count[QPTR_W-1:0];
    assign slot2  = slot1 + QPTR_W'(emit1);
    assign slot3  = slot2 + QPTR_W'(emit2);
    assign push_n = QCNT_W'(emit1) + QCNT_W'(emit2) + QCNT_W'(is_eos);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert  <= 1'b0;
            r_step    <= RST_FRAME_STEP;
            r_min_gap <= RST_MIN_GAP;
            r_min_len <= RST_MIN_LEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_INVERT:  r_invert  <= i_cfg_wdata[0];
                CFG_STEP:    r_step    <= i_cfg_wdata[1:0];
                CFG_MIN_GAP: r_min_gap <= i_cfg_wdata;
                CFG_MIN_LEN: r_min_len <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Advance stream state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_run_open   <= 1'b0;
            r_run_start  <= '0;
            r_pend_valid <= 1'b0;
            r_pend_start <= '0;
            r_pend_end   <= '0;
            r_kept       <= '0;
        end else if (in_fire) begin
            r_time       <= n_time;
            r_run_open   <= n_run_open;
            r_run_start  <= n_run_start;
            r_pend_valid <= n_pend_valid;
            r_pend_start <= n_pend_start;
            r_pend_end   <= n_pend_end;
            r_kept       <= n_kept;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (out_fire) begin
                r_head <= r_head + QPTR_W'(1);
            end
            r_count <= r_count + (in_fire ? push_n : '0) - QCNT_W'(out_fire);
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (emit1) begin
                r_queue[slot1] <= ent1;
            end
            if (emit2) begin
                r_queue[slot2] <= ent2;
            end
            if (is_eos) begin
                r_queue[slot3] <= ent3;
            end
        end
    end

    // Present the head entry
    assign head_ent     = r_queue[r_head];
    assign o_is_summary = head_ent.summ;
    assign o_seg_start  = head_ent.summ ? '0 : head_ent.v0;
    assign o_seg_end    = head_ent.summ ? '0 : head_ent.v1;
    assign o_total_time = head_ent.summ ? head_ent.v0 : '0;
    assign o_kept_time  = head_ent.summ ? head_ent.v1 : '0;
    assign o_last       = head_ent.last;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the activity segment builder. Streams of frame
// decisions and end-of-stream markers are sent under several register
// settings. A local model of segment building, padding, merging, length
// filtering and totals predicts every result item. Each result is compared
// with the oldest prediction, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import asb_pkg::*;

    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          RANDOM_ITEMS  = 350;
    localparam int          MAX_RUN_FR    = 40;
    localparam int          DUE_DEPTH     = 64;
    localparam logic [63:0] TIME_CEIL     = 64'hFFFF_FFFF;

    // One predicted result item
    typedef struct packed {
        logic        summ;
        logic [31:0] start_cs;
        logic [31:0] end_cs;
        logic [31:0] total_cs;
        logic [31:0] kept_cs;
        logic        last;
    } t_seg_item;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic                  frame_active;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  is_summary;
    logic [OUT_W-1:0]      seg_start;
    logic [OUT_W-1:0]      seg_end;
    logic [OUT_W-1:0]      total_time;
    logic [OUT_W-1:0]      kept_time;
    logic                  out_last;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Register copies held by the predictor
    logic                  cfg_invert;
    logic [1:0]            cfg_step;
    logic [CFG_DATA_W-1:0] cfg_min_gap;
    logic [CFG_DATA_W-1:0] cfg_min_len;

    // Stream state held by the predictor
    logic [63:0] t_now;
    logic        run_on;
    logic [63:0] run_t0;
    logic        held_on;
    logic [63:0] held_t0;
    logic [63:0] held_t1;
    logic [63:0] kept_total;

    t_seg_item   staged [0:2];
    int          n_staged;

    // Ring of predicted results, oldest at due_rd
    t_seg_item   due_ring [0:DUE_DEPTH-1];
    int          due_wr        = 0;
    int          due_rd        = 0;
    t_seg_item   oldest_due;

    int          mismatches    = 0;
    int          results_seen  = 0;
    int          segs_checked  = 0;
    int          totals_checked = 0;
    int          items_sent    = 0;
    int          item_cap      = 32'h7FFF_FFFF;
    int          phases_run    = 0;
    int          cycle_cnt     = 0;
    int          burst_left    = 0;
    bit          no_gaps       = 1'b0;
    int          ready_mode    = 0;
    int          ready_left    = 0;

    activity_segment_builder_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_frame_active (frame_active),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_is_summary   (is_summary),
        .o_seg_start    (seg_start),
        .o_seg_end      (seg_end),
        .o_total_time   (total_time),
        .o_kept_time    (kept_time),
        .o_last         (out_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata)
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Number of predicted results not yet seen
    function automatic int due_count();
        return due_wr - due_rd;
    endfunction

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_cnt, due_count());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TIME_CEIL) ? TIME_CEIL : s;
    endfunction

    task automatic clear_stream;
        t_now      = 64'd0;
        run_on     = 1'b0;
        run_t0     = 64'd0;
        held_on    = 1'b0;
        held_t0    = 64'd0;
        held_t1    = 64'd0;
        kept_total = 64'd0;
    endtask

    task automatic stage_result(input logic summ, input logic [63:0] s, input logic [63:0] e,
                                input logic [63:0] tot, input logic [63:0] kept);
        staged[n_staged] = '{summ, s[31:0], e[31:0], tot[31:0], kept[31:0], 1'b0};
        n_staged++;
    endtask

    // Release the held segment; keep it only if long enough
    task automatic emit_held;
        logic [63:0] len;
        if (held_on) begin
            held_on = 1'b0;
            len = held_t1 - held_t0;
            if (len >= {54'd0, cfg_min_len}) begin
                kept_total = sat_sum(kept_total, len);
                stage_result(1'b0, held_t0, held_t1, 64'd0, 64'd0);
            end
        end
    endtask

    // Merge a closed segment into the held one, or replace it
    task automatic offer_segment(input logic [63:0] s, input logic [63:0] e);
        longint ls;
        longint lh;
        longint lg;
        bit     merged;
        merged = 1'b0;
        if (held_on) begin
            ls = longint'(s);
            lh = longint'(held_t1);
            lg = longint'({54'd0, cfg_min_gap});
            if (ls - lh < lg) begin
                held_t1 = e;
                merged  = 1'b1;
            end else begin
                emit_held();
            end
        end
        if (!merged) begin
            held_on = 1'b1;
            held_t0 = s;
            held_t1 = e;
        end
    endtask

    // Work out the result items caused by one accepted input item
    task automatic build_segments(input logic k, input logic a);
        logic        sel;
        logic [63:0] half;
        logic [63:0] step64;
        logic [63:0] s;
        logic [63:0] e;
        t_seg_item   item;
        n_staged = 0;
        if (k == KIND_FRAME) begin
            sel    = a ^ cfg_invert;
            half   = {63'd0, cfg_step[1]} + {63'd0, cfg_step[0]};
            step64 = {62'd0, cfg_step};
            if (sel && !run_on) begin
                run_on = 1'b1;
                run_t0 = t_now;
            end else if (!sel && run_on) begin
                s      = (run_t0 > half) ? run_t0 - half : 64'd0;
                e      = sat_sum(t_now, half);
                run_on = 1'b0;
                offer_segment(s, e);
            end
            t_now = sat_sum(t_now, step64);
        end else begin
            // flush an open run unpadded, then the held segment, then totals
            if (run_on) begin
                run_on = 1'b0;
                offer_segment(run_t0, t_now);
            end
            emit_held();
            stage_result(1'b1, 64'd0, 64'd0, t_now, kept_total);
            clear_stream();
        end
        for (int i = 0; i < n_staged; i++) begin
            item      = staged[i];
            item.last = (i == n_staged - 1);
            due_ring[due_wr % DUE_DEPTH] = item;
            due_wr++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want_v, got_v);
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
            flag_mismatch(what, want_v, got_v);
    endtask

    // Compare each accepted result item with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (due_count() == 0) begin
                flag_mismatch("result with nothing due, seg_start", 32'd0, seg_start);
            end else begin
                oldest_due = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                check_field("is_summary", {31'd0, oldest_due.summ}, {31'd0, is_summary});
                check_field("seg_start", oldest_due.start_cs, seg_start);
                check_field("seg_end", oldest_due.end_cs, seg_end);
                check_field("total_time", oldest_due.total_cs, total_time);
                check_field("kept_time", oldest_due.kept_cs, kept_time);
                check_field("last", {31'd0, oldest_due.last}, {31'd0, out_last});
                if (oldest_due.summ)
                    totals_checked++;
                else
                    segs_checked++;
            end
        end
    end

    // Stall the result side in shifting patterns
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 40);
        end
        ready_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((ready_left % 12) >= 6);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one item; called and returning at a falling edge
    task automatic send_item(input logic k, input logic a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        kind         <= k;
        frame_active <= a;
        do @(posedge clk); while (!in_ready);
        build_segments(k, a);
        items_sent++;
        @(negedge clk);
    endtask

    // Send up to n frame items while the item budget lasts
    task automatic send_frames(input int n, input logic a);
        for (int i = 0; i < n; i++) begin
            if (items_sent < item_cap)
                send_item(KIND_FRAME, a);
        end
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic settle;
        in_valid <= 1'b0;
        while (due_count() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_INVERT:  cfg_invert  = val[0];
            CFG_STEP:    cfg_step    = val[1:0];
            CFG_MIN_GAP: cfg_min_gap = val;
            CFG_MIN_LEN: cfg_min_len = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic program_regs(input logic inv, input logic [1:0] step,
                                input logic [CFG_DATA_W-1:0] gap,
                                input logic [CFG_DATA_W-1:0] len);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_INVERT, {junk[9:1], inv});
        write_reg(CFG_STEP, {junk[9:2], step});
        write_reg(CFG_MIN_GAP, gap);
        write_reg(CFG_MIN_LEN, len);
        cfg_we <= 1'b0;
        @(negedge clk);
        phases_run++;
    endtask

    function automatic int frames_for(input int cs);
        int v;
        if (cfg_step == 2'd0)
            return int'($urandom_range(1, 4));
        v = cs / int'(cfg_step);
        return (v > MAX_RUN_FR) ? MAX_RUN_FR : v;
    endfunction

    // Frame count close to a threshold half of the time, anywhere from 1 to c + 3 otherwise
    function automatic int pick_near(input int c);
        int v;
        if ($urandom_range(0, 1))
            v = c - 2 + int'($urandom_range(0, 4));
        else
            v = int'($urandom_range(1, c + 3));
        return (v < 1) ? 1 : v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_threshold();
        if ($urandom_range(0, 5) == 0)
            return CFG_DATA_W'($urandom_range(900, 1023));
        return CFG_DATA_W'($urandom_range(0, 60));
    endfunction

    // One stream: runs around the length and gap thresholds, or noise, then end
    task automatic send_stream;
        int   nruns;
        int   nfr;
        int   lim_len;
        int   lim_gap;
        logic on_v;
        on_v    = ~cfg_invert;
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            nfr = $urandom_range(1, 20);
            for (int i = 0; i < nfr; i++) begin
                if (items_sent < item_cap)
                    send_item(KIND_FRAME, 1'($urandom_range(0, 1)));
            end
        end else begin
            lim_len = frames_for(int'(cfg_min_len));
            lim_gap = frames_for(int'(cfg_min_gap));
            send_frames($urandom_range(0, 3), ~on_v);
            nruns = $urandom_range(1, 4);
            for (int r = 0; r < nruns; r++) begin
                send_frames(pick_near(lim_len), on_v);
                // leave the last run open now and then so the end flushes it
                if (r < nruns - 1 || $urandom_range(0, 1))
                    send_frames(pick_near(lim_gap), ~on_v);
            end
        end
        send_item(KIND_EOS, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: empty streams, a run from time zero, merge, drop
    task automatic test_reset_defaults;
        send_item(KIND_EOS, 1'b0);
        send_item(KIND_EOS, 1'b1);
        repeat (10) send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_EOS, 1'b1);
        send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_EOS, 1'b0);
        settle();
    endtask

    // Inverted selection, overlapping padded segments, flush giving three results
    task automatic test_overlap_and_flush;
        program_regs(1'b1, 2'd1, 10'd0, 10'd0);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b1);
        send_item(KIND_FRAME, 1'b0);
        send_item(KIND_EOS, 1'b0);
        settle();
    endtask

    // Random streams under a sequence of settings, extremes first
    task automatic test_random_streams;
        int phase;
        int base;
        int phase_base;
        phase    = 0;
        base     = items_sent;
        item_cap = base + RANDOM_ITEMS;
        while (items_sent - base < RANDOM_ITEMS) begin
            case (phase)
                0: program_regs(1'b0, 2'd1, 10'd0, 10'd0);
                1: program_regs(1'b1, 2'd3, 10'd1023, 10'd1023);
                2: program_regs(1'($urandom_range(0, 1)), 2'd0, rand_threshold(),
                                rand_threshold());
                default: program_regs(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                      rand_threshold(), rand_threshold());
            endcase
            phase_base = items_sent;
            while (items_sent - phase_base < 40 && items_sent - base < RANDOM_ITEMS)
                send_stream();
            settle();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_FRAME;
        frame_active = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_INVERT;
        cfg_wdata    = '0;
        cfg_invert   = 1'b0;
        cfg_step     = RST_FRAME_STEP;
        cfg_min_gap  = RST_MIN_GAP;
        cfg_min_len  = RST_MIN_LEN;
        clear_stream();

        // hold reset, then release it after a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_overlap_and_flush();
        test_random_streams();
        settle();

        $display("sent %0d items under %0d register settings after the reset values",
                 items_sent, phases_run);
        $display("checked %0d segment items and %0d totals items, %0d mismatches",
                 segs_checked, totals_checked, mismatches);
        if (mismatches == 0 && due_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ activity_segment_builder_top.f @@
design/asb_pkg.sv
design/activity_segment_builder_top.sv
tb/tb_top.sv
